>>> hw/rtl/eelh_pkg.sv
// Shared types and constants for the enter/exit latency histogram.
// No dependencies; imported by every hw/rtl file but eelh_rmw_mem.
package eelh_pkg;

    localparam int CPU_W       = 3;
    localparam int TS_W        = 64;
    localparam int BUCKET_W    = 4;
    localparam int COUNT_W     = 64;
    localparam int NUM_THRESH  = 8;
    localparam int THRESH_W    = 32;
    localparam int THRESH_IDX_W = 3;
    localparam int NUM_BUCKETS = 11;

    // event kinds
    localparam logic [1:0] KIND_ENTER = 2'd0;
    localparam logic [1:0] KIND_EXIT  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // special buckets
    localparam logic [BUCKET_W-1:0] BUCKET_NONE = 4'd0;
    localparam logic [BUCKET_W-1:0] BUCKET_LAST = 4'd8;
    localparam logic [BUCKET_W-1:0] BUCKET_OVER = 4'd9;
    localparam logic [BUCKET_W-1:0] BUCKET_ERR  = 4'd10;

    // result queue
    localparam int OUTQ_AW    = 3;
    localparam int OUTQ_DEPTH = 1 << OUTQ_AW;
    localparam int OUTQ_CW    = OUTQ_AW + 1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [CPU_W-1:0]    cpu_id;
        logic [TS_W-1:0]     timestamp_ns;
        logic [BUCKET_W-1:0] bucket_select;
    } eelh_in_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic                counted;
        logic [COUNT_W-1:0]  count_value;
    } eelh_out_t;

endpackage

>>> hw/rtl/eelh_rmw_mem.sv
// Synchronous RAM with a registered read, per-entry valid bits and a
// write-to-read bypass for read-modify-write use. Depends on nothing.
module eelh_rmw_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 65,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] ram [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] ram_q_reg;
    logic [WIDTH-1:0] byp_data_reg;
    logic             byp_reg;
    logic             hit_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            ram_q_reg    <= ram[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            byp_reg     <= 1'b0;
            hit_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                // a write in the same cycle is not seen by the array read
                byp_reg     <= wr_en && (wr_addr == rd_addr);
                hit_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as zero
    assign rd_data = byp_reg ? byp_data_reg : (hit_vld_reg ? ram_q_reg : '0);

endmodule

>>> hw/rtl/eelh_bucket_pick.sv
// Bucket bounds and latency classification. Bounds are kept pre-scaled to
// nanoseconds so that no divide is needed. Depends on eelh_pkg.
module eelh_bucket_pick #(
    parameter logic [31:0] LAST_LIMIT_US = 32'd2000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [eelh_pkg::THRESH_IDX_W-1:0]   cfg_index,
    input  logic [eelh_pkg::THRESH_W-1:0]       cfg_data,
    input  logic [eelh_pkg::TS_W-1:0]           diff,
    output logic [eelh_pkg::BUCKET_W-1:0]       bucket
);

    import eelh_pkg::*;

    localparam int BOUND_W = 42;
    localparam logic [THRESH_W-1:0] THRESH_RESET [NUM_THRESH] = '{
        32'd5, 32'd10, 32'd25, 32'd50, 32'd100, 32'd250, 32'd500, 32'd1000
    };
    localparam logic [TS_W-1:0] LAST_BOUND = 64'(LAST_LIMIT_US) * 64'd1000 + 64'd999;

    // floor(ns / 1000) <= us  <=>  ns <= us * 1000 + 999
    function automatic logic [BOUND_W-1:0] scale_us(input logic [THRESH_W-1:0] us);
        return BOUND_W'(us) * 42'd1000 + 42'd999;
    endfunction

    logic [BOUND_W-1:0] bound_reg [NUM_THRESH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_THRESH; i++)
            begin
                bound_reg[i] <= scale_us(THRESH_RESET[i]);
            end
        end
        else if (cfg_write)
        begin
            bound_reg[cfg_index] <= scale_us(cfg_data);
        end
    end

    always_comb
    begin
        if (diff <= LAST_BOUND)
        begin
            bucket = BUCKET_LAST;
        end
        else
        begin
            bucket = BUCKET_OVER;
        end
        // walk down so the lowest matching bucket wins
        for (int i = NUM_THRESH - 1; i >= 0; i--)
        begin
            if (diff <= TS_W'(bound_reg[i]))
            begin
                bucket = BUCKET_W'(i);
            end
        end
    end

endmodule

>>> hw/rtl/eelh_out_queue.sv
// Result queue between the counter pipeline and the output channel.
// Depends on eelh_pkg.
module eelh_out_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  eelh_pkg::eelh_out_t           push_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output eelh_pkg::eelh_out_t           out_data,
    output logic [eelh_pkg::OUTQ_CW-1:0]  level
);

    import eelh_pkg::*;

    eelh_out_t          ram [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg;
    logic [OUTQ_AW-1:0] rd_ptr_reg;
    logic [OUTQ_CW-1:0] level_reg;
    logic               pop;

    assign out_valid = (level_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = ram[rd_ptr_reg];
    assign level     = level_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ram[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_reg + OUTQ_CW'(push) - OUTQ_CW'(pop);
        end
    end

endmodule

>>> hw/rtl/enter_exit_latency_histogram.sv
// Enter/exit latency histogram, top level. Uses eelh_pkg, eelh_rmw_mem,
// eelh_bucket_pick and eelh_out_queue.
//
// Takes one event beat per clock cycle while in_ready is high and returns
// exactly one result beat for each, in order. Each beat passes stages 1, 2
// and 3 and then the result queue before it is offered. The open entries
// (start time and owner flag per CPU) and the eleven counters sit in two
// RAMs with registered reads; each is read, updated and written back in a
// pipeline stage of its own, with a bypass when back-to-back events touch
// the same entry or counter. An eight-beat result queue decouples the
// output, and in_ready drops only when the queue plus the events in flight
// would fill it. Threshold writes take effect on the next event and are
// rescaled to nanoseconds on write.
module enter_exit_latency_histogram #(
    parameter int          NUM_CPUS      = 8,
    parameter logic [31:0] LAST_LIMIT_US = 32'd2000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  eelh_pkg::eelh_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output eelh_pkg::eelh_out_t                 out_data,
    input  logic                                cfg_write,
    input  logic [eelh_pkg::THRESH_IDX_W-1:0]   cfg_index,
    input  logic [eelh_pkg::THRESH_W-1:0]       cfg_data
);

    import eelh_pkg::*;

    localparam int CPU_AW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int ENTRY_W = TS_W + 1;

    typedef struct packed {
        logic                pick;      // latency bucket comes from the bounds
        logic                counted;
        logic                need_val;  // read beat that returns a counter
        logic [BUCKET_W-1:0] bucket;
    } eelh_ctl_t;

    logic               accept;
    logic [OUTQ_CW-1:0] q_level;
    logic [OUTQ_CW:0]   occupancy;

    // stage 1: entry read-modify-write
    logic               s1_v_reg;
    eelh_in_t           s1_item_reg;
    logic [ENTRY_W-1:0] entry_q;
    logic               entry_wr_en;
    logic [ENTRY_W-1:0] entry_wr_data;
    logic               owned;
    logic [TS_W-1:0]    start;
    logic               cpu_ok;
    logic               is_enter;
    logic               is_exit;
    logic               is_read;
    logic               enter_err;
    logic               exit_err;
    eelh_ctl_t          s1_ctl;

    // stage 2: classify and issue counter read
    logic               s2_v_reg;
    eelh_ctl_t          s2_ctl_reg;
    logic [TS_W-1:0]    s2_diff_reg;
    logic [BUCKET_W-1:0] pick_bucket;
    logic [BUCKET_W-1:0] cnt_addr;
    logic               cnt_rd_en;

    // stage 3: counter update
    logic               s3_v_reg;
    eelh_ctl_t          s3_ctl_reg;
    eelh_ctl_t          s3_ctl_next;
    logic [COUNT_W-1:0] cnt_q;
    logic [COUNT_W-1:0] cnt_inc;
    eelh_out_t          s3_beat;

    assign occupancy = (OUTQ_CW + 1)'(q_level) + (OUTQ_CW + 1)'(s1_v_reg)
                     + (OUTQ_CW + 1)'(s2_v_reg) + (OUTQ_CW + 1)'(s3_v_reg);
    assign in_ready  = (occupancy < (OUTQ_CW + 1)'(OUTQ_DEPTH));
    assign accept    = in_valid && in_ready;

    eelh_rmw_mem #(
        .DEPTH (NUM_CPUS),
        .WIDTH (ENTRY_W)
    ) u_entry_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (CPU_AW'(in_data.cpu_id)),
        .rd_data (entry_q),
        .wr_en   (entry_wr_en),
        .wr_addr (CPU_AW'(s1_item_reg.cpu_id)),
        .wr_data (entry_wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_data;
        end
        s2_ctl_reg  <= s1_ctl;
        s2_diff_reg <= s1_item_reg.timestamp_ns - start;
        s3_ctl_reg  <= s3_ctl_next;
    end

    // owner is only ever the entry's own CPU, so one flag stands for it
    assign owned = entry_q[ENTRY_W-1];
    assign start = entry_q[TS_W-1:0];

    always_comb
    begin
        cpu_ok    = s1_v_reg && (32'(s1_item_reg.cpu_id) < NUM_CPUS);
        is_enter  = cpu_ok && (s1_item_reg.kind == KIND_ENTER);
        is_exit   = cpu_ok && (s1_item_reg.kind == KIND_EXIT);
        is_read   = s1_v_reg && (s1_item_reg.kind == KIND_READ);
        enter_err = owned || (start != '0);
        exit_err  = !owned || (start == '0);

        entry_wr_en   = is_enter || is_exit;
        entry_wr_data = is_enter ? {1'b1, s1_item_reg.timestamp_ns} : '0;

        s1_ctl.pick     = is_exit && !exit_err;
        s1_ctl.counted  = (is_enter && enter_err) || is_exit;
        s1_ctl.need_val = is_read
                          && (32'(s1_item_reg.bucket_select) < NUM_BUCKETS);
        priority if ((is_enter && enter_err) || (is_exit && exit_err))
        begin
            s1_ctl.bucket = BUCKET_ERR;
        end
        else if (is_read)
        begin
            s1_ctl.bucket = s1_item_reg.bucket_select;
        end
        else
        begin
            s1_ctl.bucket = BUCKET_NONE;
        end
    end

    eelh_bucket_pick #(
        .LAST_LIMIT_US (LAST_LIMIT_US)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .diff      (s2_diff_reg),
        .bucket    (pick_bucket)
    );

    assign cnt_addr  = s2_ctl_reg.pick ? pick_bucket : s2_ctl_reg.bucket;
    assign cnt_rd_en = s2_v_reg && (s2_ctl_reg.counted || s2_ctl_reg.need_val);

    always_comb
    begin
        s3_ctl_next        = s2_ctl_reg;
        s3_ctl_next.bucket = cnt_addr;
    end

    eelh_rmw_mem #(
        .DEPTH (NUM_BUCKETS),
        .WIDTH (COUNT_W)
    ) u_count_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_addr),
        .rd_data (cnt_q),
        .wr_en   (s3_v_reg && s3_ctl_reg.counted),
        .wr_addr (s3_ctl_reg.bucket),
        .wr_data (cnt_inc)
    );

    assign cnt_inc = cnt_q + 64'd1;

    always_comb
    begin
        s3_beat.bucket  = s3_ctl_reg.bucket;
        s3_beat.counted = s3_ctl_reg.counted;
        priority if (s3_ctl_reg.counted)
        begin
            s3_beat.count_value = cnt_inc;
        end
        else if (s3_ctl_reg.need_val)
        begin
            s3_beat.count_value = cnt_q;
        end
        else
        begin
            s3_beat.count_value = '0;
        end
    end

    eelh_out_queue u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_v_reg),
        .push_data (s3_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .level     (q_level)
    );

endmodule

>>> hw/rtl/eelh_checker.sv
// Port-level checks for the latency histogram, bound to the top level.
// Depends on eelh_pkg and enter_exit_latency_histogram.
module eelh_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input eelh_pkg::eelh_in_t                  in_data,
    input logic                                out_valid,
    input logic                                out_ready,
    input eelh_pkg::eelh_out_t                 out_data
);

    import eelh_pkg::*;

    // a waiting event beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("event beat changed while waiting");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // no result appears out of an idle block straight after reset
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result beat straight after reset");

    // only real counters are ever incremented
    a_counted_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.counted |-> out_data.bucket <= BUCKET_ERR)
        else $error("increment reported on a bucket that does not exist");

    // a read of a bucket that does not exist returns zero
    a_bad_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bucket > BUCKET_ERR |->
            !out_data.counted && (out_data.count_value == '0))
        else $error("read beyond the error bucket returned data");

endmodule

bind enter_exit_latency_histogram eelh_checker u_eelh_checker (.*);

>>> tb/sv/enter_exit_latency_histogram_test.sv
// Self-checking test for enter_exit_latency_histogram: directed and random event beats,
// several threshold settings, random idling on both channels. Depends on eelh_pkg and
// the RTL of the block.
module enter_exit_latency_histogram_test;
    timeunit 1ns;
    timeprecision 1ps;

    import eelh_pkg::*;

    localparam int          NUM_CPUS      = 8;
    localparam logic [63:0] LAST_LIMIT_US = 64'd2000;
    localparam logic [63:0] NS_PER_US     = 64'd1000;
    localparam logic [3:0]  NO_OWNER      = 4'd15;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;

    localparam logic [NUM_THRESH-1:0][THRESH_W-1:0] DEFAULT_THR =
        {32'd1000, 32'd500, 32'd250, 32'd100, 32'd50, 32'd25, 32'd10, 32'd5};
    localparam logic [NUM_THRESH-1:0][THRESH_W-1:0] MIXED_THR =
        {32'd9, 32'd2, 32'hFFFF_FFFF, 32'd500, 32'd0, 32'd40, 32'd1, 32'd3};

    // threshold settings, one per random phase
    localparam int SET_RAMP    = 0;
    localparam int SET_LOW     = 1;
    localparam int SET_MAX     = 2;
    localparam int SET_MIXED   = 3;
    localparam int SET_DEFAULT = 4;
    localparam int NUM_SETTINGS = 5;

    localparam int RANDOM_PER_SETTING = 286;
    localparam int DRAIN_CYCLES       = 8;
    localparam int CYCLE_LIMIT        = 400000;

    class hist_board;
        logic [THRESH_W-1:0] thr [NUM_THRESH];
        logic [TS_W-1:0]     open_start [NUM_CPUS];
        logic [3:0]          owner [NUM_CPUS];
        logic [COUNT_W-1:0]  counts [NUM_BUCKETS];
        eelh_out_t           pending [$];
        int                  errors;

        function new();
            for (int i = 0; i < NUM_THRESH; i++)
                thr[i] = DEFAULT_THR[i];
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                open_start[i] = '0;
                owner[i] = NO_OWNER;
            end
            for (int i = 0; i < NUM_BUCKETS; i++)
                counts[i] = '0;
            errors = 0;
        endfunction

        function void set_threshold(input int idx, input logic [THRESH_W-1:0] value);
            thr[idx] = value;
        endfunction

        function logic [BUCKET_W-1:0] latency_bucket(input logic [63:0] us);
            for (int b = 0; b < NUM_THRESH; b++)
            begin
                if (us <= {32'd0, thr[b]})
                    return BUCKET_W'(b);
            end
            if (us <= LAST_LIMIT_US)
                return BUCKET_LAST;
            return BUCKET_OVER;
        endfunction

        function void note_event(input eelh_in_t ev);
            eelh_out_t         res;
            logic [BUCKET_W-1:0] b;
            int                c;
            res = '0;
            c = int'(ev.cpu_id);
            case (ev.kind)
                KIND_ENTER:
                begin
                    if (open_start[c] != '0 || owner[c] != NO_OWNER)
                    begin
                        counts[BUCKET_ERR] = counts[BUCKET_ERR] + 1;
                        res.bucket = BUCKET_ERR;
                        res.counted = 1'b1;
                        res.count_value = counts[BUCKET_ERR];
                    end
                    open_start[c] = ev.timestamp_ns;
                    owner[c] = {1'b0, ev.cpu_id};
                end
                KIND_EXIT:
                begin
                    if (owner[c] != {1'b0, ev.cpu_id} || open_start[c] == '0)
                        b = BUCKET_ERR;
                    else
                        b = latency_bucket((ev.timestamp_ns - open_start[c]) / NS_PER_US);
                    counts[b] = counts[b] + 1;
                    res.bucket = b;
                    res.counted = 1'b1;
                    res.count_value = counts[b];
                    open_start[c] = '0;
                    owner[c] = NO_OWNER;
                end
                KIND_READ:
                begin
                    res.bucket = ev.bucket_select;
                    if (ev.bucket_select < NUM_BUCKETS)
                        res.count_value = counts[ev.bucket_select];
                end
                default: ;
            endcase
            pending.push_back(res);
        endfunction

        function void check_result(input eelh_out_t got);
            eelh_out_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat bucket %0d counted %0d value %0h",
                         $time, got.bucket, got.counted, got.count_value);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.bucket !== want.bucket)
            begin
                $display("%0t: bucket expected %0d actual %0d", $time, want.bucket, got.bucket);
                errors++;
            end
            if (got.counted !== want.counted)
            begin
                $display("%0t: counted expected %0d actual %0d", $time, want.counted,
                         got.counted);
                errors++;
            end
            if (got.count_value !== want.count_value)
            begin
                $display("%0t: count_value expected %0h actual %0h", $time, want.count_value,
                         got.count_value);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    eelh_in_t                  in_data;
    logic                      out_valid;
    logic                      out_ready;
    eelh_out_t                 out_data;
    logic                      cfg_write;
    logic [THRESH_IDX_W-1:0]   cfg_index;
    logic [THRESH_W-1:0]       cfg_data;

    hist_board      board;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             beats_sent;
    int             cycles;
    logic           gen_open [NUM_CPUS];
    logic [TS_W-1:0] gen_start [NUM_CPUS];

    enter_exit_latency_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_event(in_data);
            if (out_valid && out_ready)
                board.check_result(out_data);
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // mirror of which entries are open, so that most exits pair with an enter
    function automatic void track_event(input eelh_in_t ev);
        if (ev.kind == KIND_ENTER)
        begin
            gen_open[ev.cpu_id] = 1'b1;
            gen_start[ev.cpu_id] = ev.timestamp_ns;
        end
        else if (ev.kind == KIND_EXIT)
            gen_open[ev.cpu_id] = 1'b0;
    endfunction

    // elapsed time aimed at a bucket edge or inside a bucket, or random
    function automatic logic [63:0] pick_latency_ns();
        logic [63:0] lim_us;
        logic [63:0] us;
        int          k;
        k = $urandom_range(9);
        if (k == 9)
        begin
            if ($urandom_range(3) == 0)
                return {$urandom, $urandom};
            us = LAST_LIMIT_US + 64'd1 + 64'($urandom_range(100000));
        end
        else
        begin
            lim_us = (k < NUM_THRESH) ? {32'd0, board.thr[k]} : LAST_LIMIT_US;
            case ($urandom_range(2))
                0: us = lim_us;
                1: us = lim_us + 64'd1;
                default: us = 64'($urandom_range(lim_us[31:0]));
            endcase
        end
        return us * NS_PER_US + 64'($urandom_range(999));
    endfunction

    function automatic eelh_in_t make_event();
        eelh_in_t         ev;
        int               r;
        logic [CPU_W-1:0] c;
        r = $urandom_range(99);
        c = CPU_W'($urandom_range(NUM_CPUS - 1));
        ev.kind = KIND_READ;
        ev.cpu_id = c;
        ev.timestamp_ns = {$urandom, $urandom};
        ev.bucket_select = BUCKET_W'($urandom_range(15));
        if (r < 72)
        begin
            if (gen_open[c])
            begin
                ev.kind = KIND_EXIT;
                ev.timestamp_ns = gen_start[c] + pick_latency_ns();
            end
            else
            begin
                ev.kind = KIND_ENTER;
                if (ev.timestamp_ns == '0)
                    ev.timestamp_ns = 64'd1;
            end
        end
        else if (r < 84)
        begin
            if (r < 80)
                ev.bucket_select = BUCKET_W'($urandom_range(NUM_BUCKETS - 1));
        end
        else if (r < 96)
        begin
            // double enters, stray exits, zero starts
            ev.kind = $urandom_range(1) ? KIND_EXIT : KIND_ENTER;
            if ($urandom_range(3) == 0)
                ev.timestamp_ns = '0;
        end
        else
            ev.kind = KIND_UNUSED;
        track_event(ev);
        return ev;
    endfunction

    // entered and left at a falling edge; valid stays high after the beat
    task automatic send_event(input eelh_in_t ev);
        if (beats_sent < 480)
        begin
            send_idle_pct = 8;
            recv_idle_pct = 87;
        end
        else if (beats_sent < 960)
        begin
            send_idle_pct = 87;
            recv_idle_pct = 8;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_directed(input logic [1:0] kind, input logic [CPU_W-1:0] cpu,
                                 input logic [TS_W-1:0] ts, input logic [BUCKET_W-1:0] sel);
        eelh_in_t ev;
        ev.kind = kind;
        ev.cpu_id = cpu;
        ev.timestamp_ns = ts;
        ev.bucket_select = sel;
        track_event(ev);
        send_event(ev);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_thresholds(input int setting);
        logic [THRESH_W-1:0] v;
        logic [THRESH_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < NUM_THRESH; i++)
        begin
            case (setting)
                SET_RAMP:
                begin
                    acc = acc + $urandom_range(300, 1);
                    v = acc;
                end
                SET_LOW:     v = (i < 2) ? '0 : THRESH_W'(1) << (i - 2);
                SET_MAX:     v = '1;
                SET_MIXED:   v = MIXED_THR[i];
                SET_DEFAULT: v = DEFAULT_THR[i];
                default:     v = DEFAULT_THR[i];
            endcase
            cfg_write <= 1'b1;
            cfg_index <= THRESH_IDX_W'(i);
            cfg_data <= v;
            board.set_threshold(i, v);
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        beats_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < NUM_CPUS; i++)
        begin
            gen_open[i] = 1'b0;
            gen_start[i] = '0;
        end
        board = new();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // counters after reset, error bucket and a selector past the last bucket
        send_directed(KIND_READ, 3'd0, 64'd0, 4'd0);
        send_directed(KIND_READ, 3'd7, '1, BUCKET_ERR);
        send_directed(KIND_READ, 3'd1, 64'd5, 4'd15);
        // latency exactly on the first bound, then just past it
        send_directed(KIND_ENTER, 3'd0, 64'd1000, 4'd0);
        send_directed(KIND_EXIT, 3'd0, 64'd6999, 4'd0);
        send_directed(KIND_ENTER, 3'd1, 64'h1234_5678_9ABC_DEF0, 4'd3);
        send_directed(KIND_EXIT, 3'd1, 64'h1234_5678_9ABC_DEF0 + 64'd6000, 4'd3);
        // enter at time zero leaves no start, so the exit is an error
        send_directed(KIND_ENTER, 3'd2, 64'd0, 4'd0);
        send_directed(KIND_EXIT, 3'd2, 64'd50000, 4'd0);
        // exit with nothing open
        send_directed(KIND_EXIT, 3'd3, 64'd77, 4'd0);
        // repeated enter
        send_directed(KIND_ENTER, 3'd4, 64'd100, 4'd0);
        send_directed(KIND_ENTER, 3'd4, 64'd200, 4'd0);
        send_directed(KIND_EXIT, 3'd4, 64'd300200, 4'd0);
        // elapsed time wraps past 2^64
        send_directed(KIND_ENTER, 3'd5, '1, 4'd0);
        send_directed(KIND_EXIT, 3'd5, 64'd5000, 4'd0);
        send_directed(KIND_ENTER, 3'd6, 64'd1, 4'd0);
        send_directed(KIND_EXIT, 3'd6, 64'd0, 4'd0);
        // on the last bound, then an unused kind and two more reads
        send_directed(KIND_ENTER, 3'd7, 64'd100, 4'd0);
        send_directed(KIND_EXIT, 3'd7, 64'd2000_999 + 64'd100, 4'd0);
        send_directed(KIND_UNUSED, 3'd7, '1, 4'd15);
        send_directed(KIND_READ, 3'd0, 64'd0, BUCKET_OVER);
        send_directed(KIND_READ, 3'd0, 64'd0, 4'd11);
        wait_drained();

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            load_thresholds(s);
            repeat (RANDOM_PER_SETTING) send_event(make_event());
            wait_drained();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
